// ----- sv/cmag_pkg.sv -----
// Shared widths, pipeline word type and root-bit constants for the complex magnitude block.
package cmag_pkg;

   localparam int SAMPLE_WIDTH = 32;                 // bits of each part that are used
   localparam int FIELD_WIDTH  = 32;                 // width of the input part ports
   localparam int OUT_WIDTH    = 32;                 // width of the magnitude port
   localparam int SQ_WIDTH     = 2 * SAMPLE_WIDTH;   // sum of squares
   localparam int ROOT_STAGES  = SAMPLE_WIDTH;       // one root bit per stage

   typedef logic [SAMPLE_WIDTH-1:0] abs_type;
   typedef logic [SQ_WIDTH-1:0]     sq_type;

   typedef struct packed {
      sq_type rem;
      sq_type root;
   } sqrt_word_type;

   // Trial bit of a root stage: 4^(SAMPLE_WIDTH-1-idx).
   function automatic sq_type root_bit(input int idx);
      sq_type one;
      one = sq_type'(1);
      return one << (SQ_WIDTH - 2 - 2 * idx);
   endfunction

endpackage

// ----- sv/cmag_front.sv -----
// Front end: absolute values, squares and their sum, three registered stages.
module cmag_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic [cmag_pkg::FIELD_WIDTH-1:0]    up_real_part,
   input  logic [cmag_pkg::FIELD_WIDTH-1:0]    up_imag_part,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output cmag_pkg::sqrt_word_type             dn_word
);
   import cmag_pkg::*;

   logic    abs_valid_ff, sq_valid_ff, sum_valid_ff;
   abs_type re_abs_ff, im_abs_ff, re_abs_in, im_abs_in;
   sq_type  re_sq_ff, im_sq_ff, re_sq_in, im_sq_in;
   sq_type  sum_ff, sum_in;
   logic    abs_ready, sq_ready, sum_ready;

   // a stage moves when it is empty or its neighbor takes its word
   assign sum_ready = !sum_valid_ff || dn_ready;
   assign sq_ready  = !sq_valid_ff  || sum_ready;
   assign abs_ready = !abs_valid_ff || sq_ready;
   assign up_ready  = abs_ready;

   function automatic abs_type part_abs(input logic [FIELD_WIDTH-1:0] raw);
      abs_type v;
      v = raw[SAMPLE_WIDTH-1:0];
      // most negative value maps to 2^(SAMPLE_WIDTH-1), exact in SAMPLE_WIDTH bits
      return v[SAMPLE_WIDTH-1] ? abs_type'(~v + abs_type'(1)) : v;
   endfunction

   always_comb begin
      re_abs_in = part_abs(up_real_part);
      im_abs_in = part_abs(up_imag_part);
      re_sq_in  = sq_type'(re_abs_ff) * sq_type'(re_abs_ff);
      im_sq_in  = sq_type'(im_abs_ff) * sq_type'(im_abs_ff);
      sum_in    = re_sq_ff + im_sq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (abs_ready) abs_valid_ff <= up_valid;
         if (sq_ready)  sq_valid_ff  <= abs_valid_ff;
         if (sum_ready) sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (abs_ready) begin
         re_abs_ff <= re_abs_in;
         im_abs_ff <= im_abs_in;
      end
      if (sq_ready) begin
         re_sq_ff <= re_sq_in;
         im_sq_ff <= im_sq_in;
      end
      if (sum_ready) sum_ff <= sum_in;
   end

   assign dn_valid     = sum_valid_ff;
   assign dn_word.rem  = sum_ff;
   assign dn_word.root = '0;

endmodule

// ----- sv/cmag_sqrt_cell.sv -----
// One restoring square-root stage: settles one root bit and passes the word on.
module cmag_sqrt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  cmag_pkg::sq_type           trial_bit,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  cmag_pkg::sqrt_word_type    up_word,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output cmag_pkg::sqrt_word_type    dn_word
);
   import cmag_pkg::*;

   logic          valid_ff;
   sqrt_word_type word_ff, word_in;
   sq_type        trial;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      trial = up_word.root + trial_bit;
      if (up_word.rem >= trial) begin
         word_in.rem  = up_word.rem - trial;
         word_in.root = (up_word.root >> 1) + trial_bit;
      end else begin
         word_in.rem  = up_word.rem;
         word_in.root = up_word.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

// ----- sv/complex_magnitude.sv -----
// Complex magnitude: floor(sqrt(re^2 + im^2)) of one signed sample per word.
//
// Input channel req_*: a word is taken when req_valid is high and req_stall
// low; it carries req_real_part and req_imag_part, of which the low
// SAMPLE_WIDTH bits are read as two's complement.
// Result channel rsp_*: one rsp_magnitude word per input word, in order,
// taken when rsp_valid is high and rsp_stall low.
// Pipeline: three front stages (absolute value, squares, sum) then one
// root stage per result bit, each a compare and subtract on the
// 2*SAMPLE_WIDTH-bit sum.
// Throughput: one word per clock while rsp_stall is low.
// Each stage holds one word and advances whenever the stage after it is
// empty or moving, so empty slots close up while rsp_stall is high and
// req_stall rises only once every stage is full. req_stall is low whenever
// rsp_stall is low.
// Reset (synchronous) empties every stage; nothing is in flight afterward.
module complex_magnitude (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cmag_pkg::FIELD_WIDTH-1:0] req_real_part,
   input  logic signed [cmag_pkg::FIELD_WIDTH-1:0] req_imag_part,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cmag_pkg::OUT_WIDTH-1:0]      rsp_magnitude
);
   import cmag_pkg::*;

   logic          stage_valid [0:ROOT_STAGES];
   logic          stage_ready [0:ROOT_STAGES];
   sqrt_word_type stage_word  [0:ROOT_STAGES];
   logic          front_ready;

   cmag_front u_front (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (front_ready),
      .up_real_part (req_real_part),
      .up_imag_part (req_imag_part),
      .dn_valid     (stage_valid[0]),
      .dn_ready     (stage_ready[0]),
      .dn_word      (stage_word[0])
   );

   for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_root
      cmag_sqrt_cell u_stage (
         .clock     (clock),
         .reset     (reset),
         .trial_bit (root_bit(i)),
         .up_valid  (stage_valid[i]),
         .up_ready  (stage_ready[i]),
         .up_word   (stage_word[i]),
         .dn_valid  (stage_valid[i+1]),
         .dn_ready  (stage_ready[i+1]),
         .dn_word   (stage_word[i+1])
      );
   end

   assign stage_ready[ROOT_STAGES] = !rsp_stall;
   assign req_stall     = !front_ready;
   assign rsp_valid     = stage_valid[ROOT_STAGES];
   assign rsp_magnitude = OUT_WIDTH'(stage_word[ROOT_STAGES].root[SAMPLE_WIDTH-1:0]);

endmodule

// ----- sv/cmag_checker.sv -----
// Port checker for complex_magnitude and its bind.
module cmag_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [cmag_pkg::OUT_WIDTH-1:0] rsp_magnitude
);
   import cmag_pkg::*;

   localparam logic [OUT_WIDTH:0] MaxMag = (OUT_WIDTH+1)'(64'd3037000499);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_magnitude))
      else $error("stalled result word changed");

   // input back-pressure only comes from a stalled result channel
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while result channel free");

   // root of a sum of two squares never exceeds sqrt(2) * 2^31
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_magnitude} <= MaxMag))
      else $error("magnitude out of range");

endmodule

bind complex_magnitude cmag_checker u_cmag_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_magnitude (rsp_magnitude)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the complex magnitude block: directed table, then random words.
`timescale 1ns / 100ps

module tb;
   import cmag_pkg::*;

   localparam int LATENCY     = SAMPLE_WIDTH + 3;
   localparam int HOLD_CYCLES = 4 * LATENCY;
   localparam int N_DIR       = 18;

   typedef struct {
      logic [FIELD_WIDTH-1:0] re;
      logic [FIELD_WIDTH-1:0] im;
      bit                     typed;
      logic [OUT_WIDTH-1:0]   mag;
   } dir_row_type;

   // typed = 1: expected magnitude written here; otherwise taken from the predictor
   dir_row_type dir_rows [N_DIR] = '{
      '{32'h00000000, 32'h00000000, 1'b1, 32'd0},
      '{32'h00000001, 32'h00000000, 1'b1, 32'd1},
      '{32'h00000000, 32'hFFFFFFFF, 1'b1, 32'd1},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1},
      '{32'h00000002, 32'h00000002, 1'b1, 32'd2},
      '{32'h00000003, 32'h00000004, 1'b1, 32'd5},
      '{32'hFFFFFFFD, 32'hFFFFFFFC, 1'b1, 32'd5},
      '{32'hFFFFFFFB, 32'h0000000C, 1'b1, 32'd13},
      '{32'h7FFFFFFF, 32'h00000000, 1'b1, 32'd2147483647},
      '{32'h00000000, 32'h7FFFFFFF, 1'b1, 32'd2147483647},
      '{32'h80000000, 32'h00000000, 1'b1, 32'd2147483648},
      '{32'h00000000, 32'h80000000, 1'b1, 32'd2147483648},
      '{32'h80000000, 32'h80000000, 1'b1, 32'd3037000499},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'd0},
      '{32'h80000000, 32'h7FFFFFFF, 1'b0, 32'd0},
      '{32'h7FFFFFFF, 32'h80000001, 1'b0, 32'd0},
      '{32'h55555555, 32'hAAAAAAAA, 1'b0, 32'd0},
      '{32'h0000FFFF, 32'hFFFF0000, 1'b0, 32'd0}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [FIELD_WIDTH-1:0] req_real_part;
   logic signed [FIELD_WIDTH-1:0] req_imag_part;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [OUT_WIDTH-1:0]          rsp_magnitude;

   logic [OUT_WIDTH-1:0] mag_q [$];
   int  fail_count = 0;
   bit  quiet      = 1'b0;
   bit  hold_rsp   = 1'b0;

   complex_magnitude u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // |x| of the low SAMPLE_WIDTH bits, as two's complement; most negative is exact
   function automatic logic [63:0] part_mag(input logic [FIELD_WIDTH-1:0] raw);
      logic [63:0] full;
      logic [63:0] v;
      full = 64'd1 << SAMPLE_WIDTH;
      v    = 64'(raw) & (full - 64'd1);
      if (v[SAMPLE_WIDTH-1]) return full - v;
      return v;
   endfunction

   // floor(sqrt(re^2 + im^2)), root built greedily from the top bit
   function automatic logic [OUT_WIDTH-1:0] hypot_floor(input logic [FIELD_WIDTH-1:0] re,
                                                        input logic [FIELD_WIDTH-1:0] im);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] sum;
      logic [63:0] root;
      logic [63:0] cand;
      a    = part_mag(re);
      b    = part_mag(im);
      sum  = a * a + b * b;
      root = 64'd0;
      for (int i = OUT_WIDTH - 1; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         if (cand * cand <= sum) root = cand;
      end
      return root[OUT_WIDTH-1:0];
   endfunction

   // mostly zero, some short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] rand_part();
      logic [FIELD_WIDTH-1:0] v;
      int mode;
      mode = $urandom_range(0, 9);
      case (mode)
         6: v = FIELD_WIDTH'($signed($urandom_range(0, 200)) - 100);
         7: begin
            case ($urandom_range(0, 4))
               0: v = 32'h80000000;
               1: v = 32'h7FFFFFFF;
               2: v = 32'h00000000;
               3: v = 32'h00000001;
               default: v = 32'hFFFFFFFF;
            endcase
         end
         8: v = $urandom_range(0, 1) ? 32'h80000000 + $urandom_range(0, 15)
                                     : 32'h7FFFFFFF - $urandom_range(0, 15);
         9: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_WIDTH-1:0] got,
                                  input logic [OUT_WIDTH-1:0] want);
      if (fail_count < 100)
         $display("tb: mismatch, %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_word(input logic [FIELD_WIDTH-1:0] re, input logic [FIELD_WIDTH-1:0] im,
                            input bit typed, input logic [OUT_WIDTH-1:0] mag);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_real_part <= re;
      req_imag_part <= im;
      do @(posedge clock); while (req_stall);
      mag_q.push_back(typed ? mag : hypot_floor(re, im));
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         idle_for(quiet ? 0 : gap_len());
         send_word(rand_part(), rand_part(), 1'b0, '0);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (mag_q.size() != 0) @(negedge clock);
   endtask

   // sender
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_real_part = '0;
      req_imag_part = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         idle_for(gap_len());
         send_word(dir_rows[i].re, dir_rows[i].im, dir_rows[i].typed, dir_rows[i].mag);
      end

      send_random(700);

      // receiver holds off while the sender keeps offering, so the pipe fills
      hold_rsp = 1'b1;
      quiet    = 1'b1;
      send_random(200);
      wait_drained();

      send_random(300);
      quiet = 1'b0;
      send_random(800);

      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // receiver stall pattern
   initial begin : rsp_side
      int hold_left;
      int busy_left;
      hold_left = 0;
      busy_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_rsp) begin
            hold_left = HOLD_CYCLES;
            hold_rsp  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (busy_left > 0) begin
            busy_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet) begin
            busy_left = gap_len();
            rsp_stall <= (busy_left != 0);
            if (busy_left > 0) busy_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker
   always @(posedge clock) begin : rsp_check
      logic [OUT_WIDTH-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mag_q.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_magnitude, '0);
         end else begin
            want = mag_q.pop_front();
            if (rsp_magnitude !== want) report_mismatch("magnitude", rsp_magnitude, want);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
